// ===== src/qra_pkg.sv =====
// shared types, constants and the product schedule for the quaternion accumulator
package qra_pkg;

  localparam int DATA_W        = 32;
  localparam int ACC_W         = 67;
  localparam int SQ_W          = 64;
  localparam int ROOT_W        = 33;
  localparam int FRAC_BITS_DEF = 28;

  // opcodes of an input beat
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_MUL   = 2'd1;
  localparam logic [1:0] OP_NORM  = 2'd2;
  localparam logic [1:0] OP_IDENT = 2'd3;

  // component indexes
  localparam logic [1:0] CX = 2'd0;
  localparam logic [1:0] CY = 2'd1;
  localparam logic [1:0] CZ = 2'd2;
  localparam logic [1:0] CW = 2'd3;

  typedef logic signed [DATA_W-1:0] comp_t;

  // one product term: state index, operand index, subtract
  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
  } mul_sel_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic neg;
  } mac_ctl_t;

  // hamilton product schedule, four terms per result component
  function automatic mul_sel_t mul_term(input logic [3:0] s);
    mul_sel_t t;
    case (s)
      4'd0:    t = '{ia: CY, ib: CZ, neg: 1'b0};
      4'd1:    t = '{ia: CZ, ib: CY, neg: 1'b1};
      4'd2:    t = '{ia: CW, ib: CX, neg: 1'b0};
      4'd3:    t = '{ia: CX, ib: CW, neg: 1'b0};
      4'd4:    t = '{ia: CZ, ib: CX, neg: 1'b0};
      4'd5:    t = '{ia: CX, ib: CZ, neg: 1'b1};
      4'd6:    t = '{ia: CW, ib: CY, neg: 1'b0};
      4'd7:    t = '{ia: CY, ib: CW, neg: 1'b0};
      4'd8:    t = '{ia: CX, ib: CY, neg: 1'b0};
      4'd9:    t = '{ia: CY, ib: CX, neg: 1'b1};
      4'd10:   t = '{ia: CW, ib: CZ, neg: 1'b0};
      4'd11:   t = '{ia: CZ, ib: CW, neg: 1'b0};
      4'd12:   t = '{ia: CW, ib: CW, neg: 1'b0};
      4'd13:   t = '{ia: CX, ib: CX, neg: 1'b1};
      4'd14:   t = '{ia: CY, ib: CY, neg: 1'b1};
      default: t = '{ia: CZ, ib: CZ, neg: 1'b1};
    endcase
    return t;
  endfunction

endpackage

// ===== src/qra_mac.sv =====
// shared 32x32 signed multiplier with a registered product and a wide accumulator
module qra_mac (
  input  logic                              clk,
  input  qra_pkg::mac_ctl_t                 ctl,
  input  logic signed [qra_pkg::DATA_W-1:0] a,
  input  logic signed [qra_pkg::DATA_W-1:0] b,
  output logic signed [qra_pkg::ACC_W-1:0]  acc
);
  import qra_pkg::*;

  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    base;

  // sign-extended product, negated for subtracted terms
  always_comb begin
    prod_ext = ACC_W'(prod);
    if (ctl.neg) begin
      prod_ext = -prod_ext;
    end
    base = ctl.first ? '0 : acc;
  end

  // product register then accumulate
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.acc_en) begin
      acc <= base + prod_ext;
    end
  end

endmodule

// ===== src/qra_sqrt.sv =====
// iterative integer square root, two radicand bits per cycle, rounded to nearest
module qra_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [qra_pkg::SQ_W-1:0]      rad,
  output logic                          done,
  output logic [qra_pkg::ROOT_W-1:0]    root
);
  import qra_pkg::*;

  localparam int STEPS = SQ_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [SQ_W-1:0]  rem;
  logic [SQ_W-1:0]  r;
  logic [SQ_W-1:0]  probe;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SQ_W-1:0]  trial;

  assign trial = r + probe;
  // round up when the remainder exceeds the root
  assign root  = r[ROOT_W-1:0] + ROOT_W'(rem > r);

  // one digit step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= rad;
        r     <= '0;
        probe <= SQ_W'(1) << (SQ_W - 2);
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r   <= (r >> 1) + probe;
        end else begin
          r <= r >> 1;
        end
        probe <= probe >> 2;
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/qra_div.sv =====
// restoring divider, one quotient bit per cycle
module qra_div #(
  parameter int NUM_W = qra_pkg::DATA_W + qra_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [qra_pkg::ROOT_W-1:0]    den,
  output logic                          done,
  output logic [NUM_W-1:0]              quo
);
  import qra_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num_sh;
  logic [ROOT_W-1:0] den_q;
  logic [ROOT_W-1:0] rem;
  logic [ROOT_W:0]   trial;
  logic              fits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // shift, compare and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num_sh <= num;
        den_q  <= den;
        rem    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= fits ? ROOT_W'(trial - {1'b0, den_q}) : trial[ROOT_W-1:0];
        quo    <= {quo[NUM_W-2:0], fits};
        num_sh <= num_sh << 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/quaternion_rotation_accumulator.sv =====
// Quaternion accumulator in signed fixed point (FRAC_BITS fraction bits, Q3.28 by default).
// One beat is worked at a time and in_ready is high only while the block is idle. Every
// beat runs a magnitude pass on one shared 32x32 multiplier followed by a
// 32-step square root. Multiply first adds the 16 Hamilton product terms on the same
// multiplier, and normalise runs magnitude, four bit-serial divisions of 32+FRAC_BITS
// steps each (skipped when the magnitude is zero) and magnitude again. The result
// waits in an output register until taken.
module quaternion_rotation_accumulator #(
  parameter int FRAC_BITS = qra_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [qra_pkg::DATA_W-1:0] operand_x,
  input  logic signed [qra_pkg::DATA_W-1:0] operand_y,
  input  logic signed [qra_pkg::DATA_W-1:0] operand_z,
  input  logic signed [qra_pkg::DATA_W-1:0] operand_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qra_pkg::DATA_W-1:0] result_x,
  output logic signed [qra_pkg::DATA_W-1:0] result_y,
  output logic signed [qra_pkg::DATA_W-1:0] result_z,
  output logic signed [qra_pkg::DATA_W-1:0] result_w,
  output logic [qra_pkg::DATA_W-1:0]        norm,
  output logic                              zero_norm_flag
);
  import qra_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam logic signed [DATA_W-1:0] ONE    = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  RND    = ACC_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0]  SAT_LO = ~SAT_HI;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_MUL_FIN  = 4'd2;
  localparam logic [3:0] S_MAG      = 4'd3;
  localparam logic [3:0] S_SQ_GO    = 4'd4;
  localparam logic [3:0] S_SQ_WAIT  = 4'd5;
  localparam logic [3:0] S_DIV_GO   = 4'd6;
  localparam logic [3:0] S_DIV_WAIT = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]        state;
  comp_t             quat [4];
  comp_t             opnd [4];
  comp_t             nq   [3];
  logic [3:0]        step;
  logic              phase;
  logic [1:0]        idx;
  logic              norm_pass;
  logic              flag;
  logic [ROOT_W-1:0] mag_q;

  mul_sel_t          sel;
  mac_ctl_t          mac_ctl;
  logic [1:0]        quat_ra;
  comp_t             quat_rd;
  comp_t             mac_a;
  comp_t             mac_b;
  logic signed [ACC_W-1:0] mac_acc;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [ACC_W-1:0] rnd_shr;
  comp_t             fin;
  logic [SQ_W-1:0]   rad;
  logic              sq_done;
  logic [ROOT_W-1:0] root;
  logic [DATA_W-1:0] abs_c;
  logic [NUM_W-1:0]  num;
  logic              dv_done;
  logic [NUM_W-1:0]  quo;
  comp_t             dres;

  assign in_ready = (state == S_IDLE);

  // operand selection for the shared multiplier
  always_comb begin
    sel     = mul_term(step);
    quat_ra = (state == S_MUL) ? sel.ia : idx;
    quat_rd = quat[quat_ra];
    mac_a   = quat_rd;
    mac_b   = (state == S_MUL) ? opnd[sel.ib] : quat_rd;
    mac_ctl = '0;
    if (state == S_MUL) begin
      mac_ctl.mul_en = !phase;
      mac_ctl.acc_en = phase;
      mac_ctl.first  = (step[1:0] == 2'd0);
      mac_ctl.neg    = sel.neg;
    end else if (state == S_MAG) begin
      mac_ctl.mul_en = !phase;
      mac_ctl.acc_en = phase;
      mac_ctl.first  = (idx == CX);
    end
  end

  qra_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  // round half up, drop fraction bits, saturate
  always_comb begin
    rnd_sum = mac_acc + RND;
    rnd_shr = rnd_sum >>> FRAC_BITS;
    if (rnd_shr > SAT_HI) begin
      fin = SAT_HI[DATA_W-1:0];
    end else if (rnd_shr < SAT_LO) begin
      fin = SAT_LO[DATA_W-1:0];
    end else begin
      fin = rnd_shr[DATA_W-1:0];
    end
  end

  // sum of squares saturates at all ones
  assign rad = mac_acc[SQ_W] ? '1 : mac_acc[SQ_W-1:0];

  qra_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SQ_GO),
    .rad   (rad),
    .done  (sq_done),
    .root  (root)
  );

  // scaled magnitude of one component plus half the divisor
  always_comb begin
    abs_c = quat_rd[DATA_W-1] ? DATA_W'(-quat_rd) : DATA_W'(quat_rd);
    num   = {abs_c, {FRAC_BITS{1'b0}}} + NUM_W'(mag_q[ROOT_W-1:1]);
  end

  qra_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .num   (num),
    .den   (mag_q),
    .done  (dv_done),
    .quo   (quo)
  );

  // restore sign and saturate the quotient
  always_comb begin
    if (quat_rd[DATA_W-1]) begin
      if (quo > NUM_W'(33'h080000000)) begin
        dres = SAT_LO[DATA_W-1:0];
      end else begin
        dres = -$signed(quo[DATA_W-1:0]);
      end
    end else if (quo > NUM_W'(32'h7FFFFFFF)) begin
      dres = SAT_HI[DATA_W-1:0];
    end else begin
      dres = $signed(quo[DATA_W-1:0]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      quat[0]   <= '0;
      quat[1]   <= '0;
      quat[2]   <= '0;
      quat[3]   <= ONE;
      phase     <= 1'b0;
      norm_pass <= 1'b0;
      flag      <= 1'b0;
    end else begin
      // beat taken with no new result behind it
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            flag      <= 1'b0;
            phase     <= 1'b0;
            idx       <= CX;
            step      <= '0;
            norm_pass <= 1'b0;
            state     <= S_MAG;
            case (opcode)
              OP_SET: begin
                quat[0] <= operand_x;
                quat[1] <= operand_y;
                quat[2] <= operand_z;
                quat[3] <= operand_w;
              end
              OP_MUL: begin
                opnd[0] <= operand_x;
                opnd[1] <= operand_y;
                opnd[2] <= operand_z;
                opnd[3] <= operand_w;
                state   <= S_MUL;
              end
              OP_NORM: begin
                norm_pass <= 1'b1;
              end
              default: begin
                quat[0] <= '0;
                quat[1] <= '0;
                quat[2] <= '0;
                quat[3] <= ONE;
              end
            endcase
          end
        end
        S_MUL: begin
          phase <= !phase;
          if (phase) begin
            if (step[1:0] == 2'd3) begin
              state <= S_MUL_FIN;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        S_MUL_FIN: begin
          if (step[3:2] != CW) begin
            nq[step[3:2]] <= fin;
            step          <= step + 1'b1;
            state         <= S_MUL;
          end else begin
            quat[0] <= nq[0];
            quat[1] <= nq[1];
            quat[2] <= nq[2];
            quat[3] <= fin;
            idx     <= CX;
            state   <= S_MAG;
          end
        end
        S_MAG: begin
          phase <= !phase;
          if (phase) begin
            if (idx == CW) begin
              state <= S_SQ_GO;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_SQ_GO: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_done) begin
            mag_q <= root;
            state <= S_OUT;
            if (norm_pass) begin
              norm_pass <= 1'b0;
              if (root == '0) begin
                flag <= 1'b1;
              end else begin
                idx   <= CX;
                state <= S_DIV_GO;
              end
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (dv_done) begin
            quat[idx] <= dres;
            if (idx == CW) begin
              idx   <= CX;
              state <= S_MAG;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            result_x       <= quat[0];
            result_y       <= quat[1];
            result_z       <= quat[2];
            result_w       <= quat[3];
            norm           <= mag_q[ROOT_W-1] ? '1 : mag_q[DATA_W-1:0];
            zero_norm_flag <= flag;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // root only arrives while the sequencer waits for it
  a_sq_done_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_SQ_WAIT)
    else $error("square root finished outside its wait state");

  // quotient only arrives while the sequencer waits for it
  a_dv_done_wait: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == S_DIV_WAIT)
    else $error("division finished outside its wait state");

  // a zero-magnitude flag always goes with a zero norm
  a_flag_norm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_norm_flag) |-> norm == '0)
    else $error("zero magnitude flagged with a non-zero norm");

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block stayed idle after accepting a beat");

endmodule
